### design/dsccrc_pkg.sv
// Package for the datagram synchronizer and CRC-32 frame checker.
// Holds field widths, register indexes, CRC constants and the byte-wide CRC update.
// Depends on nothing else.
`timescale 1ns / 1ps

package dsccrc_pkg;

   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 7;
   localparam int PAD_W     = 2;
   localparam int COUNT_W   = 7;
   localparam int CRC_W     = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 8;

   // Longest frame that is honored; longer programmed lengths are clamped to it.
   localparam int MAX_FRAME = 64;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [CRC_W-1:0]  CRC_POLY = 32'h04C1_1DB7;
   localparam logic [CRC_W-1:0]  CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h00;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_ID  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_LEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_COUNT = 2'd2;

   // A completed frame on its way to the compare stage.
   typedef struct packed {
      logic             header_ok;
      logic             synced;
      logic [PAD_W-1:0] pad_count;
      logic [CRC_W-1:0] crc;
      logic [CRC_W-1:0] tail;
   } frame_done_type;

   // MSB-first CRC-32 update by one byte, no reflection.
   function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_value,
                                                 input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc_value ^ {data, {(CRC_W-BYTE_W){1'b0}}};
      for (int k = 0; k < BYTE_W; k++) begin
         c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
      end
      return c;
   endfunction

endpackage

### design/datagram_sync_crc32_check_core.sv
// Top level of the datagram synchronizer and CRC-32 frame checker.
// Depends on dsccrc_pkg for widths, register indexes and the CRC update.
`timescale 1ns / 1ps

// The core takes one received byte per transfer on the req_ channel and
// returns one transfer on the rsp_ channel for each byte that completes a
// frame of frame_length bytes (clamped to 64). A frame starts on a boundary
// or on an identifier byte seen out of sync; any other byte at a boundary
// drops sync, and counting always restarts on a boundary. CRC-32 (polynomial
// 04C11DB7, seed all ones, no reflection, no final xor) runs over all but the
// last four frame bytes, pad_zero_count zero bytes are added, and the result
// is compared with the last four bytes taken most significant byte first.
// One byte is taken every clock cycle while req_stall is low; the frame
// state and the byte-wide CRC update are done in the accepting cycle, the
// padding and compare in a second stage, and the result is presented from
// an output register that the second stage loads.
// req_stall rises only when both the compare stage and the output register
// hold frames and the output is stalled. Configuration writes take effect on
// the next clock edge and should only be issued while no frame result is
// outstanding.
module datagram_sync_crc32_check_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [dsccrc_pkg::BYTE_W-1:0]        req_rx_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_header_ok,
   output logic                                 rsp_crc_ok,
   output logic                                 rsp_synced,
   input  logic                                 csr_write_en,
   input  logic [dsccrc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dsccrc_pkg::CSR_DAT_W-1:0]     csr_write_data
);
   import dsccrc_pkg::*;

   // Configuration registers.
   logic [BYTE_W-1:0]  frame_id_ff;
   logic [LEN_W-1:0]   frame_len_ff;
   logic [PAD_W-1:0]   pad_count_ff;

   // Frame tracking state.
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               in_sync_ff, in_sync_in;
   logic [CRC_W-1:0]   crc_ff, crc_in;
   logic [CRC_W-1:0]   tail_ff, tail_in;
   logic               first_match_ff, first_match_in;

   // Compare stage and output register.
   logic               done_valid_ff;
   frame_done_type     done_ff, done_in;
   logic               out_valid_ff;
   logic               out_header_ok_ff, out_crc_ok_ff, out_synced_ff;

   logic               req_take;
   logic               done_move;
   logic               frame_end;
   logic [LEN_W-1:0]   eff_len;
   logic               is_id;
   logic               at_boundary;
   logic               restart;
   logic [COUNT_W-1:0] count_base;
   logic [CRC_W-1:0]   crc_base;
   logic [CRC_W-1:0]   padded_crc;

   // Handshake. The compare stage moves on whenever the output register is
   // free or being drained; the input stalls only when that stage is stuck full.
   assign done_move = !out_valid_ff || !rsp_stall;
   assign req_stall = done_valid_ff && !done_move;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_id_ff  <= '0;
         frame_len_ff <= LEN_W'(MAX_FRAME);
         pad_count_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_FRAME_ID:  frame_id_ff  <= csr_write_data[BYTE_W-1:0];
            CSR_FRAME_LEN: frame_len_ff <= csr_write_data[LEN_W-1:0];
            CSR_PAD_COUNT: pad_count_ff <= csr_write_data[PAD_W-1:0];
            default:       ;
         endcase
      end
   end

   // Per-byte frame tracking. A byte opens a new frame on a boundary, or when
   // an identifier shows up while the block is out of sync.
   always_comb begin
      eff_len     = (frame_len_ff > LEN_W'(MAX_FRAME)) ? LEN_W'(MAX_FRAME) : frame_len_ff;
      is_id       = (req_rx_byte == frame_id_ff);
      at_boundary = (count_ff == '0) || (count_ff >= eff_len);
      restart     = at_boundary || (is_id && !in_sync_ff);
      in_sync_in  = at_boundary ? is_id : (in_sync_ff || is_id);
      count_base  = restart ? '0 : count_ff;
      count_in    = (count_base < COUNT_MAX) ? count_base + 1'b1 : count_base;

      if (count_in == COUNT_W'(1)) begin
         crc_base       = CRC_INIT;
         first_match_in = is_id;
      end else begin
         crc_base       = crc_ff;
         first_match_in = first_match_ff;
      end

      // The four trailing CRC bytes are kept out of the running CRC.
      if ({1'b0, count_in} + (COUNT_W + 1)'(4) <= {1'b0, eff_len}) begin
         crc_in = crc_feed(crc_base, req_rx_byte);
      end else begin
         crc_in = crc_base;
      end

      tail_in   = {tail_ff[CRC_W-BYTE_W-1:0], req_rx_byte};
      frame_end = (count_in == eff_len);

      done_in.header_ok = first_match_in;
      done_in.synced    = in_sync_in;
      done_in.pad_count = pad_count_ff;
      done_in.crc       = crc_in;
      done_in.tail      = tail_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         in_sync_ff     <= 1'b0;
         crc_ff         <= CRC_INIT;
         tail_ff        <= '0;
         first_match_ff <= 1'b0;
      end else if (req_take) begin
         count_ff       <= count_in;
         in_sync_ff     <= in_sync_in;
         crc_ff         <= crc_in;
         tail_ff        <= tail_in;
         first_match_ff <= first_match_in;
      end
   end

   // Compare stage register: a frame that just completed.
   always_ff @(posedge clock) begin
      if (reset) begin
         done_valid_ff <= 1'b0;
      end else if (req_take && frame_end) begin
         done_valid_ff <= 1'b1;
      end else if (done_move) begin
         done_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && frame_end) begin
         done_ff <= done_in;
      end
   end

   // Run the zero padding bytes through the CRC, then compare with the tail.
   always_comb begin
      padded_crc = done_ff.crc;
      for (int i = 0; i < 3; i++) begin
         if (PAD_W'(i) < done_ff.pad_count) begin
            padded_crc = crc_feed(padded_crc, PAD_BYTE);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (done_move) begin
         out_valid_ff <= done_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (done_move && done_valid_ff) begin
         out_header_ok_ff <= done_ff.header_ok;
         out_crc_ok_ff    <= (padded_crc == done_ff.tail);
         out_synced_ff    <= done_ff.synced;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_header_ok = out_header_ok_ff;
   assign rsp_crc_ok    = out_crc_ok_ff;
   assign rsp_synced    = out_synced_ff;

   // The byte counter never runs past the longest honored frame.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_FRAME))
      else $error("byte counter beyond the longest frame");

   // A frame held in the compare stage is never dropped while it cannot move.
   assert property (@(posedge clock) disable iff (reset)
      done_valid_ff && !done_move |=> done_valid_ff)
      else $error("completed frame lost in the compare stage");

   // The input stalls only while both the compare stage and the output register are full.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> done_valid_ff && out_valid_ff)
      else $error("input stalled without a full pipeline");

endmodule

### verif/datagram_sync_crc32_check_core_test.sv
// Self-checking testbench for datagram_sync_crc32_check_core: byte stream in, frame verdicts out.
// Runs directed CRC, reset, sync, length and back-pressure cases, then random datagrams with random handshake idling.
// Depends on dsccrc_pkg and the core RTL only.
`timescale 1ns / 1ps

module datagram_sync_crc32_check_core_test;

   // CRC-32/MPEG-2 parameters, kept locally so the checker is independent of the design.
   localparam logic [31:0] POLY32      = 32'h04C1_1DB7;
   localparam logic [31:0] SEED32      = 32'hFFFF_FFFF;
   localparam logic [7:0]  ZERO_PAD    = 8'h00;
   localparam logic [6:0]  FRAME_LIMIT = 7'd64;
   localparam logic [6:0]  COUNT_TOP   = 7'd127;
   // Two pipeline stages plus margin; used before register writes and at the end.
   localparam int          DRAIN_SLACK = 4;
   localparam int          RANDOM_BYTES   = 330;
   localparam int          RANDOM_RESULTS = 24;

   typedef struct packed {
      logic header_ok;
      logic crc_ok;
      logic synced;
   } frame_verdict_type;

   // Block ports. Every input has a known value from time zero.
   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic [dsccrc_pkg::BYTE_W-1:0]        req_rx_byte = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic                                 rsp_header_ok;
   logic                                 rsp_crc_ok;
   logic                                 rsp_synced;
   logic                                 csr_write_en = 1'b0;
   logic [dsccrc_pkg::CSR_IDX_W-1:0]     csr_index = '0;
   logic [dsccrc_pkg::CSR_DAT_W-1:0]     csr_write_data = '0;

   // Shadow copy of the configuration registers, at their reset values.
   logic [7:0]  id_reg  = 8'h00;
   logic [6:0]  len_reg = 7'd64;
   logic [1:0]  pad_reg = 2'd0;

   // Shadow copy of the framing state.
   logic [6:0]  count_q = '0;
   logic        sync_q  = 1'b0;
   logic [31:0] crc_q   = SEED32;
   logic [31:0] tail_q  = '0;
   logic        head_q  = 1'b0;

   // Verdicts predicted for frames that have completed but whose result
   // transfer has not been seen yet, oldest first.
   frame_verdict_type pending_verdicts[$];

   // Handshake control. The idle flags switch random gaps on either side; rsp_hold
   // forces the result side to stall so that the back pressure reaches req_stall.
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   bit rsp_hold    = 1'b0;
   int stall_run   = 0;
   // Set at the falling edge when a request transfer will happen at the next rising edge.
   bit req_taken   = 1'b0;

   int bytes_sent        = 0;
   int results_predicted = 0;
   int mismatches        = 0;

   datagram_sync_crc32_check_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_header_ok  (rsp_header_ok),
      .rsp_crc_ok     (rsp_crc_ok),
      .rsp_synced     (rsp_synced),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Bit-serial form of the MSB-first CRC-32 update: one data bit per shift.
   function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [7:0] data);
      logic feedback;
      for (int i = 7; i >= 0; i--) begin
         feedback = acc[31] ^ data[i];
         acc = {acc[30:0], 1'b0};
         if (feedback) acc = acc ^ POLY32;
      end
      return acc;
   endfunction

   // Programmed lengths above the largest supported frame are clamped to it.
   function automatic logic [6:0] frame_span();
      return (len_reg > FRAME_LIMIT) ? FRAME_LIMIT : len_reg;
   endfunction

   // Advances the shadow state by one accepted byte and queues a verdict when the
   // byte completes a frame.
   function automatic void predict_byte(input logic [7:0] data);
      logic [6:0]        span;
      logic              is_id;
      logic [31:0]       folded;
      frame_verdict_type verdict;
      span  = frame_span();
      is_id = (data == id_reg);
      // At a frame boundary the byte opens a new frame and decides sync on its own.
      // Inside a frame only an identifier seen while out of sync restarts the count.
      if (count_q == 7'd0 || count_q >= span) begin
         sync_q  = is_id;
         count_q = '0;
      end else if (is_id && !sync_q) begin
         sync_q  = 1'b1;
         count_q = '0;
      end
      if (count_q != COUNT_TOP) count_q = count_q + 7'd1;
      if (count_q == 7'd1) begin
         crc_q  = SEED32;
         head_q = is_id;
      end
      // The last four bytes of a frame carry the CRC and are not folded in.
      if (int'(count_q) + 4 <= int'(span)) crc_q = crc_step(crc_q, data);
      tail_q = {tail_q[23:0], data};
      if (count_q == span) begin
         folded = crc_q;
         for (int k = 0; k < int'(pad_reg); k++) folded = crc_step(folded, ZERO_PAD);
         verdict.header_ok = head_q;
         verdict.crc_ok    = (folded == tail_q);
         verdict.synced    = sync_q;
         pending_verdicts = {pending_verdicts, verdict};
         results_predicted++;
      end
   endfunction

   task automatic note_mismatch(input string what, input int want, input int got);
      $display("%0t ns: mismatch on %s, expected %0d, got %0d", $time, what, want, got);
      mismatches++;
   endtask

   task automatic check_verdict();
      frame_verdict_type want;
      if (pending_verdicts.size() == 0) begin
         note_mismatch("unexpected result transfer", 0, 1);
      end else begin
         want = pending_verdicts.pop_front();
         if (rsp_header_ok !== want.header_ok) begin
            note_mismatch("header_ok", want.header_ok, rsp_header_ok);
         end
         if (rsp_crc_ok !== want.crc_ok) begin
            note_mismatch("crc_ok", want.crc_ok, rsp_crc_ok);
         end
         if (rsp_synced !== want.synced) begin
            note_mismatch("synced", want.synced, rsp_synced);
         end
      end
   endtask

   // All inputs change just after a rising edge, so the falling edge sees settled
   // values that hold up to the next rising edge. Transfers are detected and results
   // checked here, which keeps the checks clear of any ordering within a time step.
   always @(negedge clock) begin
      req_taken = req_valid && !req_stall && !reset;
      if (!reset && rsp_valid && !rsp_stall) check_verdict();
   end

   // Result-side stall: random bursts while enabled, or a solid stall while rsp_hold is set.
   always @(posedge clock) begin
      if (rsp_hold) begin
         rsp_stall <= 1'b1;
      end else if (stall_run != 0) begin
         rsp_stall <= 1'b1;
         stall_run <= stall_run - 1;
      end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_run <= $urandom_range(0, 11);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Offers one byte, optionally after a random gap, and waits for its transfer.
   // Valid stays high on return so back-to-back bytes need no second assignment.
   task automatic send_byte(input logic [7:0] data);
      int gap;
      if (req_idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= data;
      do @(posedge clock); while (!req_taken);
      predict_byte(data);
      bytes_sent++;
   endtask

   // Sends the identifier, the body, then the CRC of both plus padding, most
   // significant byte first. With spoil set one CRC bit is flipped.
   task automatic send_crc_frame(input logic [7:0] body[$], input bit spoil);
      logic [7:0]  frame[$];
      logic [31:0] acc;
      frame = body;
      frame.push_front(id_reg);
      acc = SEED32;
      foreach (frame[i]) acc = crc_step(acc, frame[i]);
      for (int k = 0; k < int'(pad_reg); k++) acc = crc_step(acc, ZERO_PAD);
      if (spoil) acc = acc ^ (32'h1 << $urandom_range(0, 31));
      for (int k = 3; k >= 0; k--) frame = {frame, acc[8*k +: 8]};
      foreach (frame[i]) send_byte(frame[i]);
   endtask

   // Stops offering bytes and waits until every predicted result has been taken,
   // then lets the pipeline settle in case the last bytes completed no frame.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
      csr_write_en   <= 1'b1;
      csr_index      <= index;
      csr_write_data <= value;
      @(posedge clock);
   endtask

   // Writes all three registers with the block idle. Unused upper data bits get
   // random values since the block keeps only the register's own width.
   task automatic configure(input logic [7:0] id, input logic [6:0] len, input logic [1:0] pad);
      wait_idle();
      write_reg(dsccrc_pkg::CSR_FRAME_ID, id);
      id_reg = id;
      write_reg(dsccrc_pkg::CSR_FRAME_LEN, {1'($urandom_range(0, 1)), len});
      len_reg = len;
      write_reg(dsccrc_pkg::CSR_PAD_COUNT, {6'($urandom), pad});
      pad_reg = pad;
      csr_write_en <= 1'b0;
   endtask

   // One unit of random traffic: mostly well-formed datagrams with random content,
   // some with a bad CRC, an identifier inside the body, or a shortened body, and
   // some plain noise. Lengths too short for a CRC field get noise only.
   task automatic send_random_unit();
      int         span;
      int         choice;
      int         n;
      logic [7:0] body[$];
      span   = int'(frame_span());
      choice = $urandom_range(0, 9);
      if (span < 5 || choice == 0) begin
         n = $urandom_range(1, 8);
         repeat (n) send_byte(8'($urandom));
      end else begin
         repeat (span - 5) body = {body, 8'($urandom)};
         if (choice == 2 && body.size() != 0) begin
            body[$urandom_range(0, body.size() - 1)] = id_reg;
         end
         if (choice == 3) begin
            // A truncated datagram leaves the count mid-frame for the next one.
            n = $urandom_range(0, body.size());
            repeat (n) void'(body.pop_back());
            send_crc_frame(body, 1'b0);
            send_byte(8'($urandom));
         end else begin
            send_crc_frame(body, choice == 1);
         end
      end
   endtask

   // The bit-serial CRC must give the standard check value over "123456789".
   task automatic test_crc_check_value();
      string       digits;
      logic [31:0] acc;
      digits = "123456789";
      acc = SEED32;
      for (int i = 0; i < digits.len(); i++) acc = crc_step(acc, digits[i]);
      if (acc != 32'h0376_E6E7) note_mismatch("CRC check value", 32'h0376_E6E7, acc);
   endtask

   // Registers at reset: identifier 00, 64-byte frames, no padding.
   task automatic test_reset_defaults();
      logic [7:0] body[$];
      repeat (59) body = {body, 8'($urandom)};
      send_crc_frame(body, 1'b0);
   endtask

   // Sync rules on six-byte frames with one pad byte.
   task automatic test_sync_rules();
      logic [7:0] body[$];
      configure(8'hA5, 7'd6, 2'd1);
      body = {8'h00};
      send_crc_frame(body, 1'b0);
      // The identifier inside a synced frame is plain data.
      body = {8'hA5};
      send_crc_frame(body, 1'b0);
      body = {8'hFF};
      send_crc_frame(body, 1'b1);
      // A non-identifier right after a full frame drops sync; the block keeps
      // counting and reports the free-running frame as not synced.
      send_byte(8'h00);
      repeat (5) send_byte(8'hFF);
      // An identifier arriving out of sync restarts the frame.
      send_byte(8'h11);
      body = {8'h5A};
      send_crc_frame(body, 1'b0);
   endtask

   // Zero length, lengths too short for a CRC field, and a length above the limit.
   task automatic test_short_lengths();
      logic [7:0] body[$];
      configure(8'h3C, 7'd0, 2'd2);
      repeat (6) send_byte(8'($urandom));
      configure(8'h3C, 7'd1, 2'd3);
      send_byte(8'h3C);
      send_byte(8'h00);
      send_byte(8'hFF);
      configure(8'hFF, 7'd4, 2'd0);
      repeat (5) send_byte(8'($urandom));
      configure(8'hFF, 7'd5, 2'd3);
      send_crc_frame(body, 1'b0);
      configure(8'h00, 7'd127, 2'd0);
      repeat (59) body = {body, 8'($urandom)};
      send_crc_frame(body, 1'b0);
   endtask

   // One-byte frames give a result per byte; holding the result side stalled
   // fills the pipeline until req_stall pushes back on the sender.
   task automatic test_back_pressure();
      configure(8'h3C, 7'd1, 2'd0);
      rsp_hold = 1'b1;
      fork
         begin
            repeat (12) send_byte(8'($urandom));
         end
         begin
            repeat (30) @(posedge clock);
            rsp_hold = 1'b0;
         end
      join
      // Let every outstanding result drain before the random part starts.
      wait_idle();
   endtask

   task automatic test_random_frames();
      int         first_byte;
      int         first_result;
      int         units;
      logic [6:0] len;
      logic [7:0] id;
      first_byte   = bytes_sent;
      first_result = results_predicted;
      while (bytes_sent - first_byte < RANDOM_BYTES ||
             results_predicted - first_result < RANDOM_RESULTS) begin
         case ($urandom_range(0, 9))
            0:       len = 7'd6;
            1:       len = 7'd64;
            2:       len = 7'($urandom_range(0, 5));
            3:       len = 7'($urandom_range(65, 127));
            default: len = 7'($urandom_range(6, 16));
         endcase
         case ($urandom_range(0, 5))
            0:       id = 8'h00;
            1:       id = 8'hFF;
            default: id = 8'($urandom);
         endcase
         configure(id, len, 2'($urandom));
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         units = (frame_span() > 20) ? $urandom_range(2, 3) : $urandom_range(5, 10);
         repeat (units) send_random_unit();
      end
   endtask

   // Closing stretch at full rate on both sides.
   task automatic test_full_rate();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      configure(8'($urandom), 7'($urandom_range(6, 16)), 2'($urandom));
      repeat (8) send_random_unit();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_crc_check_value();
      test_reset_defaults();
      test_sync_rules();
      test_short_lengths();
      test_back_pressure();
      test_random_frames();
      test_full_rate();
      req_valid <= 1'b0;
      for (int n = 0; n < 4000 && pending_verdicts.size() != 0; n++) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
      if (pending_verdicts.size() != 0) begin
         note_mismatch("results still outstanding", pending_verdicts.size(), 0);
      end
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run, which stays under half a millisecond.
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
